// ===== src/fpba_pkg.sv =====
// shared types and constants of the fit policy block allocator
package fpba_pkg;

    // address and table entry widths
    localparam int ADDR_BITS = 16;
    localparam int END_W     = ADDR_BITS + 2;
    localparam int NEED_W    = ADDR_BITS + 1;
    localparam int ENTRY_W   = 2 * ADDR_BITS;

    // configuration register indexes
    localparam logic REG_FIT_MODE    = 1'b0;
    localparam logic REG_REGION_SIZE = 1'b1;

    // fit modes, every other code acts as worst fit
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // verdict of one gap against the current choice
    typedef struct packed {
        logic                 take;
        logic [ADDR_BITS-1:0] gap;
    } t_gap_res;

endpackage

// ===== src/fpba_gap_eval.sv =====
// gap size and fit decision for one gap of the region
module fpba_gap_eval
    import fpba_pkg::*;
(
    input  logic [ADDR_BITS-1:0] i_limit,
    input  logic [END_W-1:0]     i_prev_end,
    input  logic [NEED_W-1:0]    i_need,
    input  logic                 i_found,
    input  logic [ADDR_BITS-1:0] i_best_gap,
    input  logic [1:0]           i_fit_mode,
    output t_gap_res             o_res
);

    logic [END_W-1:0]     limit_ext;
    logic [ADDR_BITS-1:0] gap;
    logic                 fits;
    logic                 better;

    // gap from the end of the previous block up to the limit, zero if overlapped
    assign limit_ext = {2'b00, i_limit};
    assign gap  = (limit_ext > i_prev_end) ? ADDR_BITS'(limit_ext - i_prev_end) : '0;
    assign fits = ({1'b0, gap} >= i_need);

    // policy compare, strict so ties keep the lower address
    always_comb begin
        case (i_fit_mode)
            FIT_FIRST: better = 1'b0;
            FIT_BEST:  better = (gap < i_best_gap);
            default:   better = (gap > i_best_gap);
        endcase
    end

    assign o_res.take = fits && (!i_found || better);
    assign o_res.gap  = gap;

endmodule

// ===== src/fit_policy_block_allocator.sv =====
// fit policy block allocator: sorted block table in a one-port-read memory
// throughput: one request at a time, the table memory reads one entry a cycle
// for the gap scan and for the entry shift that keeps the table sorted
// reset: synchronous active low, clears the block count, config registers go to defaults
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_size[15:0], free_address[31:16]
    input  logic [0:0]  s_tuser,   // cmd[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // payload_address[15:0], status[17:16], zero pad
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CNT_W-1:0]     MAX_CNT = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]     ONE_CNT = CNT_W'(1);
    localparam logic [ADDR_BITS-1:0] HDR_A   = ADDR_BITS'(HEADER_BYTES);
    localparam logic [END_W-1:0]     HDR_E   = END_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0]    HDR_N   = NEED_W'(HEADER_BYTES);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FINAL = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // block table: [ADDR_BITS-1:0] base, upper half payload length
    logic [ENTRY_W-1:0] r_mem [MAX_BLOCKS];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [2:0]           r_state;
    logic [CNT_W-1:0]     r_count;
    logic [1:0]           r_fit_mode;
    logic [ADDR_BITS-1:0] r_region;
    logic                 r_cmd;
    logic [ADDR_BITS-1:0] r_req;
    logic [ADDR_BITS-1:0] r_faddr;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_pidx;
    logic [CNT_W-1:0]     r_left;
    logic                 r_pend;
    logic                 r_found;
    logic [END_W-1:0]     r_prev_end;
    logic [ADDR_BITS-1:0] r_best_gap;
    logic [ADDR_BITS-1:0] r_best_start;
    logic [CNT_W-1:0]     r_slot;
    logic [ADDR_BITS-1:0] r_addr;
    logic [1:0]           r_status;
    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [1:0]           r_out_status;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ADDR_BITS-1:0] ent_base;
    logic [ADDR_BITS-1:0] ent_len;
    logic [END_W-1:0]     ent_end;
    logic                 free_hit;
    logic [NEED_W-1:0]    need;
    logic [ADDR_BITS-1:0] limit;
    t_gap_res             gap_res;
    logic                 fin_found;
    logic [CNT_W-1:0]     fin_slot;
    logic [ADDR_BITS-1:0] fin_start;
    logic [CNT_W-1:0]     shift_wr_idx;

    // read port: table scan walks up, shift walks either way
    assign rd_en   = ((r_state == S_SCAN) && (r_idx < r_count)) ||
                     ((r_state == S_SHIFT) && (r_left != '0));
    assign rd_addr = r_idx[IDX_W-1:0];

    // write port: shifted entry or the new block
    assign shift_wr_idx = (r_cmd == CMD_ALLOC) ? (r_pidx + ONE_CNT) : (r_pidx - ONE_CNT);
    assign wr_en   = ((r_state == S_SHIFT) && r_pend) || (r_state == S_PLACE);
    assign wr_addr = (r_state == S_PLACE) ? r_slot[IDX_W-1:0] : shift_wr_idx[IDX_W-1:0];
    assign wr_data = (r_state == S_PLACE) ? {r_req, r_best_start} : r_rd_data;

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // fields of the entry just read
    assign ent_base = r_rd_data[ADDR_BITS-1:0];
    assign ent_len  = r_rd_data[ENTRY_W-1:ADDR_BITS];
    assign ent_end  = {2'b00, ent_base} + HDR_E + {2'b00, ent_len};
    assign free_hit = ((ent_base + HDR_A) == r_faddr);
    assign need     = HDR_N + {1'b0, r_req};
    assign limit    = (r_state == S_FINAL) ? r_region : ent_base;

    fpba_gap_eval u_gap (
        .i_limit    (limit),
        .i_prev_end (r_prev_end),
        .i_need     (need),
        .i_found    (r_found),
        .i_best_gap (r_best_gap),
        .i_fit_mode (r_fit_mode),
        .o_res      (gap_res)
    );

    // choice after the gap behind the last block
    assign fin_found = r_found || gap_res.take;
    assign fin_slot  = gap_res.take ? r_count : r_slot;
    assign fin_start = gap_res.take ? r_prev_end[ADDR_BITS-1:0] : r_best_start;

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fit_mode  <= FIT_FIRST;
            r_region    <= 16'hFFFF;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_FIT_MODE:    r_fit_mode <= i_cfg_wdata[1:0];
                    REG_REGION_SIZE: r_region   <= i_cfg_wdata;
                endcase
            end

            // result transfer frees the output register
            if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_cmd        <= s_tuser[0];
                        r_req        <= s_tdata[15:0];
                        r_faddr      <= s_tdata[31:16];
                        r_idx        <= '0;
                        r_pend       <= 1'b0;
                        r_found      <= 1'b0;
                        r_prev_end   <= '0;
                        r_best_gap   <= '0;
                        r_best_start <= '0;
                        r_slot       <= '0;
                        if ((s_tuser[0] == CMD_ALLOC) && (r_count == MAX_CNT)) begin
                            r_status <= ST_FULL;
                            r_addr   <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (rd_en) begin
                        r_idx  <= r_idx + ONE_CNT;
                        r_pidx <= r_idx;
                    end
                    r_pend <= rd_en;
                    if (r_pend) begin
                        if (r_cmd == CMD_FREE) begin
                            // first match: close the hole above it
                            if (free_hit) begin
                                r_left  <= r_count - r_pidx - ONE_CNT;
                                r_idx   <= r_pidx + ONE_CNT;
                                r_pend  <= 1'b0;
                                r_state <= S_SHIFT;
                            end
                        end else begin
                            // gap in front of this block
                            if (gap_res.take) begin
                                r_found      <= 1'b1;
                                r_best_gap   <= gap_res.gap;
                                r_best_start <= r_prev_end[ADDR_BITS-1:0];
                                r_slot       <= r_pidx;
                            end
                            if (ent_end > r_prev_end) begin
                                r_prev_end <= ent_end;
                            end
                        end
                    end else if (!rd_en) begin
                        if (r_cmd == CMD_FREE) begin
                            r_status <= ST_NOT_FOUND;
                            r_addr   <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_FINAL;
                        end
                    end
                end

                S_FINAL: begin
                    if (!fin_found) begin
                        r_status <= ST_NO_FIT;
                        r_addr   <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_slot       <= fin_slot;
                        r_best_start <= fin_start;
                        r_left       <= r_count - fin_slot;
                        r_idx        <= r_count - ONE_CNT;
                        r_pend       <= 1'b0;
                        r_status     <= ST_OK;
                        r_addr       <= fin_start + HDR_A;
                        r_state      <= S_SHIFT;
                    end
                end

                S_SHIFT: begin
                    if (rd_en) begin
                        r_idx  <= (r_cmd == CMD_ALLOC) ? (r_idx - ONE_CNT) : (r_idx + ONE_CNT);
                        r_pidx <= r_idx;
                        r_left <= r_left - ONE_CNT;
                    end
                    r_pend <= rd_en;
                    if (!rd_en && !r_pend) begin
                        if (r_cmd == CMD_ALLOC) begin
                            r_state <= S_PLACE;
                        end else begin
                            r_count  <= r_count - ONE_CNT;
                            r_status <= ST_OK;
                            r_addr   <= '0;
                            r_state  <= S_DONE;
                        end
                    end
                end

                S_PLACE: begin
                    r_count <= r_count + ONE_CNT;
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (!r_out_valid || m_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_addr   <= r_addr;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // stream outputs
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'b000000, r_out_status, r_out_addr};

endmodule

// ===== src/fpba_checker.sv =====
// port level checks of the fit policy block allocator and their binding
module fpba_port_checks
    import fpba_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // no result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a failed request never reports an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[17:16] != ST_OK) |-> (m_tdata[15:0] == 16'd0))
        else $error("failed request with nonzero address");

    // one request at a time: busy right after a request transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[23:18] == 6'd0))
        else $error("result pad bits set");

endmodule

bind fit_policy_block_allocator fpba_port_checks u_fpba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/fpba_checker.sv =====
// result checker for the fit policy block allocator: block table tracking and compare
`timescale 1ns / 100ps

module fpba_checker
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request stream, observed only
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [31:0]              s_tdata,   // request_size[15:0], free_address[31:16]
    input  logic [0:0]               s_tuser,   // cmd[0]
    // result stream, observed only
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [23:0]              m_tdata,   // payload_address[15:0], status[17:16], pad
    // configuration writes, observed only
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_addr,
    input  logic [15:0]              i_cfg_wdata,
    // status toward the stimulus side
    output int                       o_pending,
    output int                       o_live_count,
    output logic [MAX_BLOCKS*16-1:0] o_live_addrs,  // payload address of entry i at [16*i +: 16]
    output int                       o_mismatches
);

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_alloc_answer;

    // tracked allocator state
    logic [1:0]    fit_mode_r;
    logic [15:0]   region_r;
    logic [15:0]   base_tab [MAX_BLOCKS];
    logic [15:0]   len_tab  [MAX_BLOCKS];
    int            live_cnt;

    t_alloc_answer answer_q [$];
    int            mismatch_cnt = 0;
    int            result_cnt   = 0;

    assign o_mismatches = mismatch_cnt;

    task automatic report_mismatch(input string what, input logic [23:0] want,
                                   input logic [23:0] got);
        if (mismatch_cnt < 30)
            $display("[%0t] result %0d: %s expected %h got %h",
                     $time, result_cnt, what, want, got);
        mismatch_cnt++;
    endtask

    // gap search over the sorted table, then insert at the chosen slot
    task automatic serve_alloc(input logic [15:0] req, output t_alloc_answer res);
        int i;
        int need;
        int prev_end;
        int lim;
        int gap;
        int blk_end;
        int best_gap;
        int best_start;
        int best_slot;
        bit found;
        bit take;
        res.addr   = 16'd0;
        res.status = ST_OK;
        if (live_cnt >= MAX_BLOCKS) begin
            res.status = ST_FULL;
        end else begin
            need       = HEADER_BYTES + int'(req);
            prev_end   = 0;
            best_gap   = 0;
            best_start = 0;
            best_slot  = 0;
            found      = 1'b0;
            for (i = 0; i <= live_cnt; i++) begin
                lim = (i < live_cnt) ? int'(base_tab[i]) : int'(region_r);
                gap = (lim > prev_end) ? lim - prev_end : 0;
                if (gap >= need) begin
                    if (!found) begin
                        take = 1'b1;
                    end else begin
                        case (fit_mode_r)
                            FIT_FIRST: take = 1'b0;
                            FIT_BEST:  take = (gap < best_gap);
                            default:   take = (gap > best_gap);
                        endcase
                    end
                    if (take) begin
                        found      = 1'b1;
                        best_gap   = gap;
                        best_start = prev_end;
                        best_slot  = i;
                    end
                    if (fit_mode_r == FIT_FIRST)
                        break;
                end
                if (i < live_cnt) begin
                    blk_end = int'(base_tab[i]) + HEADER_BYTES + int'(len_tab[i]);
                    if (blk_end > prev_end)
                        prev_end = blk_end;
                end
            end
            if (!found) begin
                res.status = ST_NO_FIT;
            end else begin
                for (i = live_cnt; i > best_slot; i--) begin
                    base_tab[i] = base_tab[i-1];
                    len_tab[i]  = len_tab[i-1];
                end
                base_tab[best_slot] = 16'(best_start);
                len_tab[best_slot]  = req;
                live_cnt++;
                res.addr = 16'(best_start + HEADER_BYTES);
            end
        end
    endtask

    // remove the lowest entry whose payload address matches
    task automatic serve_free(input logic [15:0] faddr, output t_alloc_answer res);
        int i;
        int hit;
        logic [15:0] pay;
        res.addr   = 16'd0;
        res.status = ST_NOT_FOUND;
        hit        = -1;
        for (i = 0; i < live_cnt; i++) begin
            pay = 16'(int'(base_tab[i]) + HEADER_BYTES);
            if (hit < 0 && pay == faddr)
                hit = i;
        end
        if (hit >= 0) begin
            for (i = hit; i + 1 < live_cnt; i++) begin
                base_tab[i] = base_tab[i+1];
                len_tab[i]  = len_tab[i+1];
            end
            live_cnt--;
            res.status = ST_OK;
        end
    endtask

    // watch all three channels at the clock edge
    always @(posedge i_clk) begin
        t_alloc_answer res;
        t_alloc_answer want;
        logic [MAX_BLOCKS*16-1:0] live_vec;
        if (!i_rst_n) begin
            fit_mode_r = FIT_FIRST;
            region_r   = 16'hFFFF;
            live_cnt   = 0;
            for (int k = 0; k < MAX_BLOCKS; k++) begin
                base_tab[k] = 16'd0;
                len_tab[k]  = 16'd0;
            end
            answer_q.delete();
        end else begin
            // results first, so a transfer in this cycle never pairs with a new request
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result with no request outstanding", 24'd0, m_tdata);
                end else begin
                    want = answer_q.pop_front();
                    if (m_tdata[15:0] !== want.addr)
                        report_mismatch("payload_address", 24'(want.addr),
                                        24'(m_tdata[15:0]));
                    if (m_tdata[17:16] !== want.status)
                        report_mismatch("status", 24'(want.status), 24'(m_tdata[17:16]));
                    if (m_tdata[23:18] !== 6'd0)
                        report_mismatch("pad bits", 24'd0, 24'(m_tdata[23:18]));
                end
                result_cnt++;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_FIT_MODE:    fit_mode_r = i_cfg_wdata[1:0];
                    REG_REGION_SIZE: region_r   = i_cfg_wdata;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == CMD_ALLOC)
                    serve_alloc(s_tdata[15:0], res);
                else
                    serve_free(s_tdata[31:16], res);
                answer_q.push_back(res);
            end
        end
        // registered view for the stimulus side
        for (int k = 0; k < MAX_BLOCKS; k++)
            live_vec[16*k +: 16] = (k < live_cnt) ? 16'(int'(base_tab[k]) + HEADER_BYTES)
                                                  : 16'd0;
        o_live_addrs <= live_vec;
        o_live_count <= live_cnt;
        o_pending    <= answer_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the allocator testbench: clock, reset, stimulus, settings and verdict
`timescale 1ns / 100ps

module testbench
    import fpba_pkg::*;
();

    localparam int MAX_BLOCKS     = 16;
    localparam int HEADER_BYTES   = 24;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 50;
    localparam int PHASE_ITEMS    = 75;
    localparam int PHASES         = 8;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = 32'd0;
    logic [0:0]  s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_addr  = REG_FIT_MODE;
    logic [15:0] i_cfg_wdata = 16'd0;

    int                       pending;
    int                       live_count;
    logic [MAX_BLOCKS*16-1:0] live_addrs;
    int                       mismatches;

    // idle percentages per side, and the long receiver stall
    int   tx_idle_pct = 16;
    int   rx_idle_pct = 65;
    logic rx_hold_req = 1'b0;
    logic rx_hold_done = 1'b0;
    int   rx_hold_left = 0;

    int   region_now = 65535;
    int   n_alloc    = 0;
    int   n_free     = 0;
    int   n_settings = 0;
    int   cycle_cnt  = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    fit_policy_block_allocator #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    fpba_checker #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_live_count(live_count),
        .o_live_addrs(live_addrs),
        .o_mismatches(mismatches)
    );

    // result side: random back-pressure, plus one long stall on request
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req && !rx_hold_done) begin
            m_tready     <= 1'b0;
            rx_hold_left <= RX_HOLD_CYCLES;
            rx_hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // run limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
        $display("TB_ERROR");
        $finish;
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_item(input logic cmd, input logic [15:0] req, input logic [15:0] faddr);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {faddr, req};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        if (cmd == CMD_ALLOC)
            n_alloc++;
        else
            n_free++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // both registers, written while the allocator is idle
    task automatic write_settings(input logic [1:0] mode, input logic [15:0] region);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_FIT_MODE;
        i_cfg_wdata <= {14'd0, mode};
        @(posedge i_clk);
        i_cfg_addr  <= REG_REGION_SIZE;
        i_cfg_wdata <= region;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        region_now = int'(region);
        n_settings++;
    endtask

    // mostly sized to the region and freeing live blocks, some noise
    task automatic send_random();
        logic        cmd;
        logic [15:0] req;
        logic [15:0] faddr;
        int          pick;
        int          sel;
        req   = 16'($urandom());
        faddr = 16'($urandom());
        pick  = $urandom_range(99);
        if ($urandom_range(99) < 55) begin
            cmd = CMD_ALLOC;
            if (pick < 80) begin
                req = 16'($urandom_range(region_now / 6));
            end else if (pick < 90) begin
                case ($urandom_range(3))
                    0: req = 16'd0;
                    1: req = 16'hFFFF;
                    2: req = 16'((region_now > HEADER_BYTES) ? region_now - HEADER_BYTES : 0);
                    default: req = 16'($urandom_range(64));
                endcase
            end
        end else begin
            cmd = CMD_FREE;
            if (live_count > 0 && pick < 85) begin
                sel   = $urandom_range(live_count - 1);
                faddr = live_addrs[16*sel +: 16];
                // near miss on a live address
                if (pick >= 75)
                    faddr = faddr + (($urandom_range(1) == 0) ? 16'd1 : 16'hFFFF);
            end
        end
        send_item(cmd, req, faddr);
    endtask

    // stimulus and verdict
    initial begin
        logic [15:0] region_set [PHASES];
        int ph;
        int n;
        region_set = '{16'd1500, 16'd0, 16'hFFFF, 16'd400, 16'd0, 16'd8000, 16'd0, 16'hFFFF};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset settings: first fit, full region
        send_item(CMD_FREE,  16'($urandom()), 16'd24);       // free on an empty table
        send_item(CMD_ALLOC, 16'd0,           16'($urandom()));   // header only
        send_item(CMD_ALLOC, 16'hFFFF,        16'($urandom()));   // nothing fits
        send_item(CMD_ALLOC, 16'd100,         16'($urandom()));
        send_item(CMD_FREE,  16'($urandom()), 16'd24);       // opens a gap at the bottom
        send_item(CMD_ALLOC, 16'd0,           16'($urandom()));   // exact fit of that gap
        send_item(CMD_FREE,  16'($urandom()), 16'hFFFF);
        send_item(CMD_FREE,  16'($urandom()), 16'h5555);
        for (n = 0; n < 14; n++)
            send_item(CMD_ALLOC, 16'd1, 16'($urandom()));     // fills the table
        send_item(CMD_ALLOC, 16'd1,           16'($urandom()));   // table full
        send_item(CMD_FREE,  16'($urandom()), 16'hAAAA);
        send_item(CMD_FREE,  16'($urandom()), 16'd48);
        drain();

        // random phases, each under its own settings
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 3) begin
                tx_idle_pct <= 65;
                rx_idle_pct <= 16;
            end else if (ph == 6) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            if (region_set[ph] == 16'd0 && ph != 1)
                write_settings(ph[1:0], 16'($urandom_range(65535, 600)));
            else
                write_settings(ph[1:0], region_set[ph]);
            if (ph == 4)
                rx_hold_req <= 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests (%0d allocate, %0d free) under %0d register settings",
                 n_alloc + n_free, n_alloc, n_free, n_settings);
        $display("fit modes 0 to 3, region 0 to 65535, full table, one %0d-cycle result stall",
                 RX_HOLD_CYCLES);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== fit_policy_block_allocator.f =====
src/fpba_pkg.sv
src/fpba_gap_eval.sv
src/fit_policy_block_allocator.sv
src/fpba_checker.sv
tb/sv/fpba_checker.sv
tb/sv/testbench.sv
